[hw/rtl/lkv_pkg.sv]
`timescale 1ns / 1ps
// lkv_pkg: shared types and constants of the LRU key-value cache.
// No dependencies; used by every module of the block.
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W  = IDX_W;
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;

   localparam logic [CAP_W-1:0]        CAP_RESET  = CAP_W'(16);
   localparam logic [IDX_W-1:0]        LAST_IDX   = IDX_W'(ENTRIES - 1);
   localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      opcode_type              opcode;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] read_value;
      logic                    evicted;
   } rsp_type;

   // sequencer -> datapath controls
   typedef struct packed {
      logic             accept;
      logic             scan;
      logic             update;
      logic [IDX_W-1:0] idx;
   } ctl_type;

   // one stored entry as seen by the scan comparator
   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
      logic [RANK_W-1:0]       rank;
   } row_type;

   // scan findings handed to the update step
   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  hit_idx;
      logic [RANK_W-1:0] hit_rank;
      logic              any_valid;
      logic [IDX_W-1:0]  old_idx;
      logic              has_free;
      logic [IDX_W-1:0]  free_idx;
   } scan_type;

endpackage

[hw/rtl/lkv_ctrl.sv]
`timescale 1ns / 1ps
// lkv_ctrl: sequencer that steps the shared comparator over all entries,
// or skips the scan while capacity is zero. Depends on lkv_pkg.
module lkv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             cap_zero,
   output logic             busy,
   output lkv_pkg::ctl_type ctl
);
   import lkv_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (start) begin
               state_in = cap_zero ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      ctl.accept = start && (state_ff == ST_IDLE);
      ctl.scan   = (state_ff == ST_SCAN);
      ctl.update = (state_ff == ST_UPDATE);
      ctl.idx    = idx_ff;
   end

endmodule

[hw/rtl/lkv_scan.sv]
`timescale 1ns / 1ps
// lkv_scan: shared key/rank comparator, one entry per cycle.
// Tracks key match, least recent entry and first free slot. Depends on lkv_pkg.
module lkv_scan (
   input  logic                           clock,
   input  lkv_pkg::ctl_type               ctl,
   input  logic signed [lkv_pkg::KEY_W-1:0] key,
   input  lkv_pkg::row_type               row,
   output lkv_pkg::scan_type              result
);
   import lkv_pkg::*;

   scan_type          res_ff, res_in;
   logic [RANK_W-1:0] old_rank_ff, old_rank_in;
   logic              key_eq;
   logic              older;

   assign key_eq = row.valid && (row.key == key);
   // first valid entry seeds the search; later ones must be strictly older
   assign older  = row.valid && (!res_ff.any_valid || (row.rank > old_rank_ff));

   always_comb begin
      res_in      = res_ff;
      old_rank_in = old_rank_ff;
      if (ctl.accept) begin
         res_in      = '0;
         old_rank_in = '0;
      end else if (ctl.scan) begin
         if (key_eq && !res_ff.found) begin
            res_in.found    = 1'b1;
            res_in.hit_idx  = ctl.idx;
            res_in.hit_rank = row.rank;
         end
         if (older) begin
            res_in.any_valid = 1'b1;
            res_in.old_idx   = ctl.idx;
            old_rank_in      = row.rank;
         end
         if (!row.valid && !res_ff.has_free) begin
            res_in.has_free = 1'b1;
            res_in.free_idx = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      old_rank_ff <= old_rank_in;
   end

   assign result = res_ff;

endmodule

[hw/rtl/lkv_store.sv]
`timescale 1ns / 1ps
// lkv_store: entry storage, recency ranks, occupancy and response registers.
// Applies the update step from the scan findings. Depends on lkv_pkg.
module lkv_store (
   input  logic                         clock,
   input  logic                         reset,
   input  lkv_pkg::ctl_type             ctl,
   input  logic [lkv_pkg::OCC_W-1:0]    cap_sat,
   input  lkv_pkg::req_type             req,
   input  lkv_pkg::scan_type            scan,
   output lkv_pkg::row_type             row,
   output logic                         rsp_valid,
   output lkv_pkg::rsp_type             rsp_data
);
   import lkv_pkg::*;

   logic                    valid_ff [ENTRIES];
   logic                    valid_in [ENTRIES];
   logic signed [KEY_W-1:0] key_ff   [ENTRIES];
   logic signed [VAL_W-1:0] value_ff [ENTRIES];
   logic [RANK_W-1:0]       rank_ff  [ENTRIES];
   logic [RANK_W-1:0]       rank_in  [ENTRIES];
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic             enabled;
   logic             is_put;
   logic             hit;
   logic             miss_put;
   logic             do_evict;
   logic             do_ins;
   logic [IDX_W-1:0] ins_idx;
   logic             wr_value;
   logic [IDX_W-1:0] wr_idx;
   logic             valid_after;

   assign enabled  = (cap_sat != '0);
   assign is_put   = (req.opcode == OP_PUT);
   assign hit      = enabled && scan.found;
   assign miss_put = enabled && !scan.found && is_put;
   assign do_evict = miss_put && (occ_ff >= cap_sat) && scan.any_valid;
   // after an eviction the lowest free slot is the lower of the old free slot
   // and the slot just vacated
   assign ins_idx  = do_evict ?
                     ((scan.has_free && (scan.free_idx < scan.old_idx)) ?
                      scan.free_idx : scan.old_idx) :
                     scan.free_idx;
   assign do_ins   = miss_put && (do_evict || scan.has_free);
   assign wr_value = ctl.update && ((hit && is_put) || do_ins);
   assign wr_idx   = hit ? scan.hit_idx : ins_idx;

   // row seen by the scan comparator
   assign row.valid = valid_ff[ctl.idx];
   assign row.key   = key_ff[ctl.idx];
   assign row.rank  = rank_ff[ctl.idx];

   // per-entry rank and valid update, independent for every entry
   always_comb begin
      valid_after = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (ctl.update && hit) begin
            if (IDX_W'(i) == scan.hit_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < scan.hit_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (ctl.update && miss_put) begin
            valid_after = valid_ff[i] && !(do_evict && (IDX_W'(i) == scan.old_idx));
            valid_in[i] = valid_after;
            if (do_ins) begin
               if (IDX_W'(i) == ins_idx) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end else if (valid_after) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctl.update) begin
         occ_in = occ_ff - OCC_W'(do_evict) + OCC_W'(do_ins);
      end
      rsp_in.hit        = hit;
      rsp_in.read_value = (hit && !is_put) ? value_ff[scan.hit_idx] : MISS_VALUE;
      rsp_in.evicted    = do_evict;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= ctl.update;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_ff[i] <= rank_in[i];
      end
      if (wr_value) begin
         value_ff[wr_idx] <= req.value;
      end
      if (ctl.update && do_ins) begin
         key_ff[ins_idx] <= req.key;
      end
      if (ctl.update) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/lru_key_value_cache_unit.sv]
`timescale 1ns / 1ps
// lru_key_value_cache_unit: top level of the fully associative LRU cache.
// Depends on lkv_pkg, lkv_ctrl, lkv_scan and lkv_store.
// Each transaction scans every entry and then runs the update step; the scan
//   is skipped while capacity is zero. A new start is not taken while busy.
// The single key/rank comparator steps through the 16 entries, one per cycle.
// The response strobe lasts one cycle and cannot be stalled; the next start
//   can be taken at the edge that ends it.
// Reset (synchronous): all entries invalid, occupancy 0, capacity 16.
module lru_key_value_cache_unit (
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      start,
   output logic                      busy,
   input  lkv_pkg::req_type          req_data,
   // response
   output logic                      rsp_valid,
   output lkv_pkg::rsp_type          rsp_data,
   // capacity register
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0] csr_data
);
   import lkv_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [OCC_W-1:0] cap_sat;
   req_type          req_ff, req_in;
   ctl_type          ctl;
   row_type          row;
   scan_type         scan;

   // capacity: written only while idle and no transaction is being taken;
   // values above ENTRIES saturate
   assign csr_ready = ~busy & ~start;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;
   assign cap_sat   = (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) ? OCC_W'(ENTRIES) :
                                                           OCC_W'(cap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // request transaction held for the whole scan/update
   assign req_in = ctl.accept ? req_data : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   lkv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cap_zero (cap_sat == '0),
      .busy     (busy),
      .ctl      (ctl)
   );

   lkv_scan u_scan (
      .clock  (clock),
      .ctl    (ctl),
      .key    (req_ff.key),
      .row    (row),
      .result (scan)
   );

   lkv_store u_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cap_sat   (cap_sat),
      .req       (req_ff),
      .scan      (scan),
      .row       (row),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/lkv_checker.sv]
`timescale 1ns / 1ps
// lkv_checker: port-level assertions for the LRU cache, bound to the top.
// Depends on lkv_pkg and lru_key_value_cache_unit.
module lkv_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lkv_pkg::rsp_type rsp_data
);
   import lkv_pkg::*;

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // the response strobe lasts a single cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // finishing a transaction always presents its response
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a response");

   // a miss never carries data
   a_miss_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == MISS_VALUE)
      else $error("miss response carries data");

   // eviction happens only on a put miss; the check is that a hit never reports one
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> !rsp_data.hit)
      else $error("eviction reported on a hit");

endmodule

bind lru_key_value_cache_unit lkv_checker u_checker (.*);
